// ===== rtl/spc_pkg.sv =====
// Shared widths, word types and constants for the sphere pair contact block.
// No dependencies; used by sphere_pair_contact and spc_isqrt.
`default_nettype none

package spc_pkg;

    localparam int CoordW = 32;          // Q16.16 coordinates
    localparam int RadW   = 31;          // unsigned Q15.16 radius
    localparam int DeltaW = 33;          // center difference, signed
    localparam int SqW    = 66;          // squared length radicand
    localparam int RootW  = SqW / 2;     // square root width
    localparam int UnW    = 31;          // scaled delta magnitude
    localparam int LenW   = 32;          // scaled length
    localparam int NumW   = 48;          // divider numerator
    localparam int QuotW  = 16;          // divider quotient
    localparam int NormW  = 16;          // Q1.15 normal
    localparam int PenW   = 34;          // signed penetration
    localparam int TW     = 34;          // signed lever arm
    localparam int ProdW  = 50;          // normal times lever arm
    localparam int RndW   = 36;          // rounded product, signed
    localparam int SumW   = 37;          // point before saturation

    localparam logic [NormW-1:0] NormPosMax   = 16'h7FFF;
    localparam logic [QuotW-1:0] NormNegLimit = 16'h8000;
    localparam logic [14:0]      RoundHalf    = 15'h4000;

    typedef struct packed {
        logic [2:0][CoordW-1:0] a;
        logic [RadW-1:0]        ra;
        logic [RadW-1:0]        rb;
        logic [2:0][UnW-1:0]    un;
        logic                   mz;
    } side_t;

    typedef struct packed {
        logic [2:0][CoordW-1:0] a;
        logic [CoordW-1:0]      depth;
        logic [TW-1:0]          t;
        logic                   hit;
        logic [2:0]             neg;
        logic                   mz;
        logic [LenW-1:0]        len;
    } dv_t;

endpackage

`default_nettype wire

// ===== rtl/spc_isqrt.sv =====
// Pipelined floor square root, one root bit per register stage, with sideband.
// Depends on spc_pkg for its default width.
`default_nettype none

module spc_isqrt #(
    parameter int RW = spc_pkg::SqW,
    parameter int SW = 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [RW-1:0]     rad,
    input  wire logic [SW-1:0]     in_side,
    output logic                   out_valid,
    output logic [RW/2-1:0]        root,
    output logic [SW-1:0]          out_side
);
    localparam int QW = RW / 2;

    logic          v_reg    [QW];
    logic [RW-1:0] rem_reg  [QW];
    logic [QW-1:0] root_reg [QW];
    logic [SW-1:0] side_reg [QW];

    genvar j;
    generate
        for (j = 0; j < QW; j++) begin : g_stage
            localparam int K = QW - 1 - j;
            logic          v_in;
            logic [RW-1:0] rem_in;
            logic [QW-1:0] root_in;
            logic [SW-1:0] side_in;
            logic [RW:0]   trial;
            logic          take;

            if (j == 0) begin : g_first
                assign v_in    = in_valid;
                assign rem_in  = rad;
                assign root_in = '0;
                assign side_in = in_side;
            end else begin : g_next
                assign v_in    = v_reg[j-1];
                assign rem_in  = rem_reg[j-1];
                assign root_in = root_reg[j-1];
                assign side_in = side_reg[j-1];
            end

            // (root + 2^K)^2 - root^2 = root * 2^(K+1) + 2^(2K)
            assign trial = ((RW+1)'(root_in) << (K + 1)) | ((RW+1)'(1) << (2 * K));
            assign take  = {1'b0, rem_in} >= trial;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[j] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[j] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j]  <= take ? (rem_in - trial[RW-1:0]) : rem_in;
                    root_reg[j] <= take ? (root_in | (QW'(1) << K)) : root_in;
                    side_reg[j] <= side_in;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[QW-1];
    assign root      = root_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

`default_nettype wire

// ===== rtl/sphere_pair_contact.sv =====
// Top level of the sphere pair contact pipeline.
// Depends on spc_pkg and spc_isqrt.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, a_*, a_radius, b_*,   | into block
//          | b_radius                                  |
//  out     | out_valid, out_stall, touching, normal_*, | out of block
//          | depth, point_*                            |
//
// One word enters per clock unless stalled. Stages: 7 front, 33 square
// root (one root bit each), numerator, 16 divider (one quotient bit
// each), then back end. rst_n clears only the valid bits. A stall on the
// out channel holds every stage while out_valid is high; in_stall is high
// only while the last stage holds a word the out channel does not take.
`default_nettype none

module sphere_pair_contact (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic signed [spc_pkg::CoordW-1:0]  a_x,
    input  wire logic signed [spc_pkg::CoordW-1:0]  a_y,
    input  wire logic signed [spc_pkg::CoordW-1:0]  a_z,
    input  wire logic        [spc_pkg::RadW-1:0]    a_radius,
    input  wire logic signed [spc_pkg::CoordW-1:0]  b_x,
    input  wire logic signed [spc_pkg::CoordW-1:0]  b_y,
    input  wire logic signed [spc_pkg::CoordW-1:0]  b_z,
    input  wire logic        [spc_pkg::RadW-1:0]    b_radius,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic                                    touching,
    output logic signed [spc_pkg::NormW-1:0]        normal_x,
    output logic signed [spc_pkg::NormW-1:0]        normal_y,
    output logic signed [spc_pkg::NormW-1:0]        normal_z,
    output logic        [spc_pkg::CoordW-1:0]       depth,
    output logic signed [spc_pkg::CoordW-1:0]       point_x,
    output logic signed [spc_pkg::CoordW-1:0]       point_y,
    output logic signed [spc_pkg::CoordW-1:0]       point_z
);
    import spc_pkg::*;

    typedef struct packed {
        logic [2:0][CoordW-1:0] a;
        logic [RadW-1:0]        ra;
        logic [RadW-1:0]        rb;
        logic [2:0]             neg;
    } base_t;

    logic adv;

    // Advance the whole pipe unless the out word is held.
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // ---------------------------------------------------------------
    // Stage 1: capture the in word.
    // ---------------------------------------------------------------
    logic                     v1_reg;
    logic [2:0][CoordW-1:0]   a1_reg, b1_reg;
    logic [RadW-1:0]          ra1_reg, rb1_reg;

    // ---------------------------------------------------------------
    // Stage 2: center difference and its magnitude.
    // ---------------------------------------------------------------
    logic                     v2_reg;
    base_t                    base2_reg;
    logic [2:0][DeltaW-1:0]   u2_reg;
    logic [2:0][DeltaW-1:0]   d2_next, u2_next;

    // Stage 3: squares for the distance, largest magnitude.
    logic                     v3_reg;
    base_t                    base3_reg;
    logic [2:0][DeltaW-1:0]   u3_reg;
    logic [2:0][SqW-1:0]      sq3_reg;
    logic [DeltaW-1:0]        m3_reg, m3_next;

    // Stage 4: squared distance, normalizing shift.
    logic                     v4_reg;
    base_t                    base4_reg;
    logic [2:0][DeltaW-1:0]   u4_reg;
    logic [SqW-1:0]           dsum4_reg;
    logic [4:0]               sl4_reg, sl4_next;
    logic [1:0]               sr4_reg, sr4_next;
    logic                     mz4_reg;
    logic [5:0]               lead;

    // Stage 5: scaled magnitudes.
    logic                     v5_reg;
    base_t                    base5_reg;
    logic [SqW-1:0]           dsum5_reg;
    logic [2:0][UnW-1:0]      un5_reg, un5_next;
    logic                     mz5_reg;

    // Stage 6: squares of the scaled magnitudes.
    logic                     v6_reg;
    base_t                    base6_reg;
    logic [SqW-1:0]           dsum6_reg;
    logic [2:0][UnW-1:0]      un6_reg;
    logic [2:0][2*UnW-1:0]    usq6_reg;
    logic                     mz6_reg;

    // Stage 7: scaled squared length.
    logic                     v7_reg;
    base_t                    base7_reg;
    logic [SqW-1:0]           dsum7_reg;
    logic [2:0][UnW-1:0]      un7_reg;
    logic [SqW-3:0]           s2_7_reg;
    logic                     mz7_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d2_next[i] = {b1_reg[i][CoordW-1], b1_reg[i]} - {a1_reg[i][CoordW-1], a1_reg[i]};
            u2_next[i] = d2_next[i][DeltaW-1] ? (~d2_next[i] + DeltaW'(1)) : d2_next[i];
        end
    end

    always_comb
    begin
        m3_next = u2_reg[0];
        if (u2_reg[1] > m3_next)
        begin
            m3_next = u2_reg[1];
        end
        if (u2_reg[2] > m3_next)
        begin
            m3_next = u2_reg[2];
        end
    end

    // Find the leading one; place it at bit 30.
    always_comb
    begin
        lead = '0;
        for (int b = 0; b < DeltaW; b++)
        begin
            if (m3_reg[b])
            begin
                lead = 6'(b);
            end
        end
        sl4_next = (lead < 6'd30) ? 5'(6'd30 - lead) : 5'd0;
        sr4_next = (lead > 6'd30) ? 2'(lead - 6'd30) : 2'd0;
    end

    always_comb
    begin
        logic [63:0] wide;
        for (int i = 0; i < 3; i++)
        begin
            wide       = (64'(u4_reg[i]) << sl4_reg) >> sr4_reg;
            un5_next[i] = wide[UnW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_reg  <= {a_z, a_y, a_x};
            b1_reg  <= {b_z, b_y, b_x};
            ra1_reg <= a_radius;
            rb1_reg <= b_radius;

            base2_reg.a  <= a1_reg;
            base2_reg.ra <= ra1_reg;
            base2_reg.rb <= rb1_reg;
            for (int i = 0; i < 3; i++)
            begin
                base2_reg.neg[i] <= d2_next[i][DeltaW-1];
            end
            u2_reg <= u2_next;

            base3_reg <= base2_reg;
            u3_reg    <= u2_reg;
            m3_reg    <= m3_next;
            for (int i = 0; i < 3; i++)
            begin
                sq3_reg[i] <= u2_reg[i] * u2_reg[i];
            end

            base4_reg <= base3_reg;
            u4_reg    <= u3_reg;
            dsum4_reg <= sq3_reg[0] + sq3_reg[1] + sq3_reg[2];
            sl4_reg   <= sl4_next;
            sr4_reg   <= sr4_next;
            mz4_reg   <= (m3_reg == '0);

            base5_reg <= base4_reg;
            dsum5_reg <= dsum4_reg;
            un5_reg   <= un5_next;
            mz5_reg   <= mz4_reg;

            base6_reg <= base5_reg;
            dsum6_reg <= dsum5_reg;
            un6_reg   <= un5_reg;
            mz6_reg   <= mz5_reg;
            for (int i = 0; i < 3; i++)
            begin
                usq6_reg[i] <= un5_reg[i] * un5_reg[i];
            end

            base7_reg <= base6_reg;
            dsum7_reg <= dsum6_reg;
            un7_reg   <= un6_reg;
            mz7_reg   <= mz6_reg;
            s2_7_reg  <= (SqW-2)'(usq6_reg[0]) + (SqW-2)'(usq6_reg[1])
                       + (SqW-2)'(usq6_reg[2]);
        end
    end

    // ---------------------------------------------------------------
    // Two square roots side by side: center distance and scaled length.
    // ---------------------------------------------------------------
    side_t              side7;
    side_t              side_sq;
    logic               vdist, vlen, vsq;
    logic [RootW-1:0]   center_len, lenw;
    logic [2:0]         neg_sq;

    always_comb
    begin
        side7.a  = base7_reg.a;
        side7.ra = base7_reg.ra;
        side7.rb = base7_reg.rb;
        side7.un = un7_reg;
        side7.mz = mz7_reg;
    end

    spc_isqrt #(
        .RW (SqW),
        .SW ($bits(side_t))
    ) u_dist_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v7_reg),
        .rad       (dsum7_reg),
        .in_side   (side7),
        .out_valid (vdist),
        .root      (center_len),
        .out_side  (side_sq)
    );

    spc_isqrt #(
        .RW (SqW),
        .SW (3)
    ) u_len_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v7_reg),
        .rad       ({2'b00, s2_7_reg}),
        .in_side   (base7_reg.neg),
        .out_valid (vlen),
        .root      (lenw),
        .out_side  (neg_sq)
    );

    assign vsq = vdist && vlen;

    // ---------------------------------------------------------------
    // Penetration, lever arm, divider numerators, then one quotient bit
    // per stage in three lanes.
    // ---------------------------------------------------------------
    logic                   dv_v_reg [QuotW+1];
    dv_t                    dv_reg   [QuotW+1];
    logic [2:0][NumW-1:0]   rem_reg  [QuotW+1];
    logic [2:0][QuotW-1:0]  q_reg    [QuotW+1];

    logic signed [PenW-1:0] pen;
    logic signed [TW-1:0]   t_c;
    logic [LenW-1:0]        len_c;
    dv_t                    dv0_next;
    logic [2:0][NumW-1:0]   num0_next;

    always_comb
    begin
        len_c = lenw[LenW-1:0];
        pen   = $signed({3'b000, side_sq.ra}) + $signed({3'b000, side_sq.rb})
              - $signed({1'b0, center_len});
        t_c   = $signed({3'b000, side_sq.ra}) - (pen >>> 1);

        dv0_next.a     = side_sq.a;
        dv0_next.depth = pen[CoordW-1:0];
        dv0_next.t     = t_c;
        dv0_next.hit   = !pen[PenW-1] && (pen != '0);
        dv0_next.neg   = neg_sq;
        dv0_next.mz    = side_sq.mz;
        dv0_next.len   = len_c;
        for (int i = 0; i < 3; i++)
        begin
            num0_next[i] = NumW'({side_sq.un[i], 15'b0}) + NumW'(len_c >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            dv_v_reg[0] <= vsq;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_reg[0]  <= dv0_next;
            rem_reg[0] <= num0_next;
            q_reg[0]   <= '0;
        end
    end

    genvar j;
    generate
        for (j = 1; j <= QuotW; j++) begin : g_div
            localparam int K = QuotW - j;
            logic [NumW-1:0]       trial;
            logic [2:0][NumW-1:0]  rem_next;
            logic [2:0][QuotW-1:0] q_next;

            assign trial = NumW'(dv_reg[j-1].len) << K;

            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (rem_reg[j-1][i] >= trial)
                    begin
                        rem_next[i] = rem_reg[j-1][i] - trial;
                        q_next[i]   = q_reg[j-1][i] | (QuotW'(1) << K);
                    end
                    else
                    begin
                        rem_next[i] = rem_reg[j-1][i];
                        q_next[i]   = q_reg[j-1][i];
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dv_v_reg[j] <= 1'b0;
                end
                else if (adv)
                begin
                    dv_v_reg[j] <= dv_v_reg[j-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dv_reg[j]  <= dv_reg[j-1];
                    rem_reg[j] <= rem_next;
                    q_reg[j]   <= q_next;
                end
            end
        end
    endgenerate

    // ---------------------------------------------------------------
    // Back end: sign and clamp the normal, multiply, round, add, saturate.
    // ---------------------------------------------------------------
    logic                          vn_reg, vm_reg, vr_reg, vo_reg;
    logic [2:0][NormW-1:0]         n_reg, n_next, nm_reg, nr_reg;
    logic [2:0][CoordW-1:0]        an_reg, am_reg, ar_reg;
    logic [CoordW-1:0]             depn_reg, depm_reg, depr_reg;
    logic                          hitn_reg, hitm_reg, hitr_reg;
    logic signed [TW-1:0]          tn_reg;
    logic [2:0][ProdW-1:0]         prod_reg;
    logic [2:0][RndW-1:0]          rnd_reg, rnd_next;
    logic [2:0][CoordW-1:0]        pt_next;

    logic                          touching_reg;
    logic [2:0][NormW-1:0]         normal_reg;
    logic [CoordW-1:0]             depth_reg;
    logic [2:0][CoordW-1:0]        point_reg;

    always_comb
    begin
        logic [QuotW-1:0] q;
        for (int i = 0; i < 3; i++)
        begin
            q = q_reg[QuotW][i];
            if (dv_reg[QuotW].neg[i])
            begin
                n_next[i] = (q > NormNegLimit) ? NormNegLimit : (~q + QuotW'(1));
            end
            else
            begin
                n_next[i] = (q > NormPosMax) ? NormPosMax : q;
            end
        end
        // Coincident centers: fall back to +x.
        if (dv_reg[QuotW].mz)
        begin
            n_next[0] = NormPosMax;
            n_next[1] = '0;
            n_next[2] = '0;
        end
    end

    always_comb
    begin
        logic signed [ProdW-1:0] p;
        logic [ProdW-1:0]        mag;
        logic [ProdW-1:0]        rm;
        for (int i = 0; i < 3; i++)
        begin
            p   = $signed(prod_reg[i]);
            mag = p[ProdW-1] ? (~prod_reg[i] + ProdW'(1)) : prod_reg[i];
            rm  = (mag + ProdW'(RoundHalf)) >> 15;
            rnd_next[i] = p[ProdW-1] ? (~rm[RndW-1:0] + RndW'(1)) : rm[RndW-1:0];
        end
    end

    always_comb
    begin
        logic signed [SumW-1:0] s;
        for (int i = 0; i < 3; i++)
        begin
            s = $signed({{(SumW-CoordW){ar_reg[i][CoordW-1]}}, ar_reg[i]})
              + $signed({rnd_reg[i][RndW-1], rnd_reg[i]});
            if (s > $signed(SumW'(32'h7FFF_FFFF)))
            begin
                pt_next[i] = 32'h7FFF_FFFF;
            end
            else if (s < -$signed(SumW'(32'h8000_0000)))
            begin
                pt_next[i] = 32'h8000_0000;
            end
            else
            begin
                pt_next[i] = s[CoordW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vn_reg <= 1'b0;
            vm_reg <= 1'b0;
            vr_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            vn_reg <= dv_v_reg[QuotW];
            vm_reg <= vn_reg;
            vr_reg <= vm_reg;
            vo_reg <= vr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n_reg    <= n_next;
            an_reg   <= dv_reg[QuotW].a;
            depn_reg <= dv_reg[QuotW].depth;
            hitn_reg <= dv_reg[QuotW].hit;
            tn_reg   <= $signed(dv_reg[QuotW].t);

            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= $signed(n_reg[i]) * tn_reg;
            end
            nm_reg   <= n_reg;
            am_reg   <= an_reg;
            depm_reg <= depn_reg;
            hitm_reg <= hitn_reg;

            rnd_reg  <= rnd_next;
            nr_reg   <= nm_reg;
            ar_reg   <= am_reg;
            depr_reg <= depm_reg;
            hitr_reg <= hitm_reg;

            // Drop every field to zero when the spheres do not touch.
            touching_reg <= hitr_reg;
            normal_reg   <= hitr_reg ? nr_reg : '0;
            depth_reg    <= hitr_reg ? depr_reg : '0;
            point_reg    <= hitr_reg ? pt_next : '0;
        end
    end

    assign out_valid = vo_reg;
    assign touching  = touching_reg;
    assign normal_x  = normal_reg[0];
    assign normal_y  = normal_reg[1];
    assign normal_z  = normal_reg[2];
    assign depth     = depth_reg;
    assign point_x   = point_reg[0];
    assign point_y   = point_reg[1];
    assign point_z   = point_reg[2];

endmodule

`default_nettype wire

// ===== bench/sphere_pair_contact_tb.sv =====
// Self-checking bench for sphere_pair_contact: drives sphere pairs, predicts contacts.
// Depends on spc_pkg and the sphere_pair_contact RTL.
`timescale 1ns / 100ps

module sphere_pair_contact_tb;
    import spc_pkg::*;

    typedef struct {
        logic signed [31:0] ax, ay, az;
        logic [30:0]        ra;
        logic signed [31:0] bx, by, bz;
        logic [30:0]        rb;
    } pair_t;

    typedef struct {
        logic               touching;
        logic signed [15:0] nx, ny, nz;
        logic [31:0]        depth;
        logic signed [31:0] px, py, pz;
    } contact_t;

    localparam int WatchdogLimit = 20000;
    localparam int Latency       = 61;
    localparam int HoldCycles    = 200;

    logic clk, rst_n;
    logic in_valid, in_stall, out_valid, out_stall;
    logic signed [31:0] a_x, a_y, a_z, b_x, b_y, b_z;
    logic [30:0] a_radius, b_radius;
    logic touching;
    logic signed [15:0] normal_x, normal_y, normal_z;
    logic [31:0] depth;
    logic signed [31:0] point_x, point_y, point_z;

    pair_t    pending_pairs[$];
    contact_t expected_contacts[$];
    int  errors = 0;
    int  send_idle_pct = 0, stall_pct = 0;
    bit  hold_req = 0;
    bit  hold_done;
    int  hold_left;
    int  idle_cycles = 0;

    sphere_pair_contact i_dut (.*);

    always
    begin
        clk = 1'b1; #5;
        clk = 1'b0; #5;
    end

    // Floor square root of a value below 2^68.
    function automatic logic [33:0] floor_sqrt(input logic [67:0] v);
        logic [33:0] r, c;
        r = '0;
        for (int b = 33; b >= 0; b--)
        begin
            c = r | (34'd1 << b);
            if ({34'd0, c} * {34'd0, c} <= v) r = c;
        end
        return r;
    endfunction

    function automatic logic signed [63:0] round_shift15(input logic signed [63:0] v);
        logic [63:0] m;
        m = v < 0 ? -v : v;
        m = (m + 64'd16384) >> 15;
        return v < 0 ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic contact_t predict_contact(input pair_t p);
        contact_t c;
        logic signed [63:0] a[3], d[3], n[3], pen, t;
        logic [63:0] u[3], m, s2, len, q;
        logic [67:0] sq;
        logic [33:0] root_dist;
        a[0] = p.ax; a[1] = p.ay; a[2] = p.az;
        d[0] = 64'(p.bx) - a[0]; d[1] = 64'(p.by) - a[1]; d[2] = 64'(p.bz) - a[2];
        sq = '0;
        for (int i = 0; i < 3; i++)
        begin
            u[i] = d[i] < 0 ? -d[i] : d[i];
            sq += {4'd0, u[i]} * {4'd0, u[i]};
        end
        root_dist = floor_sqrt(sq);
        pen = 64'(p.ra) + 64'(p.rb) - 64'(root_dist);
        c = '{default: '0};
        if (pen <= 0) return c;
        m = u[0];
        if (u[1] > m) m = u[1];
        if (u[2] > m) m = u[2];
        if (m == 0)
        begin
            n[0] = 32767; n[1] = 0; n[2] = 0;
        end
        else
        begin
            while (m >= 64'h8000_0000)
            begin
                m >>= 1;
                for (int i = 0; i < 3; i++) u[i] >>= 1;
            end
            while (m < 64'h4000_0000)
            begin
                m <<= 1;
                for (int i = 0; i < 3; i++) u[i] <<= 1;
            end
            s2 = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
            len = 64'(floor_sqrt({4'd0, s2}));
            for (int i = 0; i < 3; i++)
            begin
                q = (u[i] * 32768 + (len >> 1)) / len;
                if (d[i] < 0) n[i] = -$signed(q > 32768 ? 64'd32768 : q);
                else          n[i] = $signed(q > 32767 ? 64'd32767 : q);
            end
        end
        t = 64'(p.ra) - (pen >>> 1);
        c.touching = 1'b1;
        c.nx = n[0][15:0]; c.ny = n[1][15:0]; c.nz = n[2][15:0];
        c.depth = pen[31:0];
        c.px = 32'(clamp32(a[0] + round_shift15(n[0] * t)));
        c.py = 32'(clamp32(a[1] + round_shift15(n[1] * t)));
        c.pz = 32'(clamp32(a[2] + round_shift15(n[2] * t)));
        return c;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            2: return 32'($signed($urandom_range(0, 60000)) - 30000);
            default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    function automatic pair_t rand_pair();
        pair_t p;
        p.ax = rand_coord(); p.ay = rand_coord(); p.az = rand_coord();
        // Mostly place B near A so that most pairs touch.
        if ($urandom_range(0, 3) != 0)
        begin
            p.bx = p.ax + 32'($signed($urandom_range(0, 400000)) - 200000);
            p.by = p.ay + 32'($signed($urandom_range(0, 400000)) - 200000);
            p.bz = p.az + 32'($signed($urandom_range(0, 400000)) - 200000);
            p.ra = 31'($urandom_range(0, 300000));
            p.rb = 31'($urandom_range(0, 300000));
        end
        else
        begin
            p.bx = rand_coord(); p.by = rand_coord(); p.bz = rand_coord();
            p.ra = 31'($urandom); p.rb = 31'($urandom);
        end
        return p;
    endfunction

    function automatic pair_t build_pair(input logic [31:0] ax, ay, az, input logic [30:0] ra,
                                         input logic [31:0] bx, by, bz, input logic [30:0] rb);
        pair_t p;
        p.ax = ax; p.ay = ay; p.az = az; p.ra = ra;
        p.bx = bx; p.by = by; p.bz = bz; p.rb = rb;
        return p;
    endfunction

    // Append one pair to the pending queue.
    task automatic add_pending(input pair_t p);
        pending_pairs = {pending_pairs, p};
    endtask

    // Driver: advance to the next pending word once the current one is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            {a_x, a_y, a_z, b_x, b_y, b_z} <= '0;
            {a_radius, b_radius} <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                pair_t p;
                p = pending_pairs.pop_front();
                expected_contacts = {expected_contacts, predict_contact(p)};
                in_valid <= 1'b1;
                a_x <= p.ax; a_y <= p.ay; a_z <= p.az; a_radius <= p.ra;
                b_x <= p.bx; b_y <= p.by; b_z <= p.bz; b_radius <= p.rb;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: random, or held high for a counted stretch once requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (hold_req && !hold_done)
            begin
                hold_left <= HoldCycles;
                hold_done <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
            end
            out_stall <= (hold_left > 0) || ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Monitor: compare each taken result with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (out_valid && !out_stall)
            begin
                if (expected_contacts.size() == 0)
                begin
                    errors++;
                    if (errors <= 10) $display("unexpected result word at %0t", $realtime);
                end
                else
                begin
                    contact_t e;
                    e = expected_contacts.pop_front();
                    if (touching !== e.touching || normal_x !== e.nx || normal_y !== e.ny ||
                        normal_z !== e.nz || depth !== e.depth || point_x !== e.px ||
                        point_y !== e.py || point_z !== e.pz)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("mismatch exp t=%0d n=%0d,%0d,%0d d=%h p=%h,%h,%h",
                                     e.touching, e.nx, e.ny, e.nz, e.depth, e.px, e.py, e.pz);
                            $display("         got t=%0d n=%0d,%0d,%0d d=%h p=%h,%h,%h",
                                     touching, normal_x, normal_y, normal_z, depth,
                                     point_x, point_y, point_z);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: stop when nothing moves for too long.
    always @(posedge clk)
    begin
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_pairs.size() > 0 || in_valid || expected_contacts.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, coincident centers, just-touching and separated pairs.
        add_pending(build_pair(0, 0, 0, 31'h10000, 0, 0, 0, 31'h10000));
        add_pending(build_pair(0, 0, 0, 0, 0, 0, 0, 0));
        add_pending(build_pair(0, 0, 0, 31'h10000, 32'h20000, 0, 0, 31'h10000));
        add_pending(build_pair(0, 0, 0, 31'h10000, 32'h1FFFF, 0, 0, 31'h10000));
        add_pending(build_pair(0, 0, 0, 31'h10000, 0, 32'hFFFF0000, 0, 31'h8000));
        add_pending(build_pair(0, 0, 0, 31'h10000, 0, 0, 32'hFFFF8000, 31'h8000));
        add_pending(build_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h7FFF_FFFF, 31'h7FFF_FFFF));
        add_pending(build_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               31'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                               32'h8000_0000, 31'h7FFF_FFFF));
        add_pending(build_pair(32'h7FFF_FFF0, 0, 32'h8000_0010, 31'h7FFF_FFFF,
                               32'h7FFF_FFF0, 0, 32'h8000_0010, 31'h7FFF_FFFF));
        add_pending(build_pair(0, 0, 0, 31'h7FFF_FFFF, 1, 1, 1, 0));
        add_pending(build_pair(0, 0, 0, 1, 0, 0, 0, 0));
        add_pending(build_pair(5, 7, 9, 31'h3000, 5, 7, 9, 31'h5000));
        add_pending(build_pair(0, 0, 0, 31'h10000, 32'h10000, 32'h10000,
                               32'h10000, 31'h10000));
        add_pending(build_pair(0, 0, 0, 31'h100, 32'h7FFF_FFFF, 0, 0, 31'h100));
        wait_drained();

        // Random phases: none, sender idle, receiver stall, both.
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1) ? 50 : (ph == 3) ? 13 : 0;
            stall_pct     = (ph == 2) ? 50 : (ph == 3) ? 13 : 0;
            for (int k = 0; k < 470; k++) add_pending(rand_pair());
            if (ph == 0)
            begin
                // Long hold-off while the sender keeps offering words.
                repeat (20) @(posedge clk);
                hold_req <= 1'b1;
            end
            wait_drained();
        end

        repeat (Latency + 10) @(posedge clk);
        if (errors == 0 && expected_contacts.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// ===== sphere_pair_contact.f =====
rtl/spc_pkg.sv
rtl/spc_isqrt.sv
rtl/sphere_pair_contact.sv
bench/sphere_pair_contact_tb.sv
